/* sv/quicksort_first_pivot_macros.svh */
// Assertion macros for the quicksort block.
// Used by quicksort_first_pivot and qfp_dp; needs clk_i and rst_ni in scope.
`ifndef QUICKSORT_FIRST_PIVOT_MACROS_SVH
`define QUICKSORT_FIRST_PIVOT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define QFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define QFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/qfp_pkg.sv */
// Shared types and constants of the quicksort block.
// No dependencies; used by qfp_ctrl, qfp_dp and quicksort_first_pivot.
package qfp_pkg;

  localparam int QFP_DEPTH = 64;
  localparam int QFP_WIDTH = 32;
  localparam int QFP_VAL_W = 32;

  typedef struct packed {
    logic signed [QFP_VAL_W-1:0] value;
    logic                        is_last;
  } qfp_in_t;

  typedef struct packed {
    logic signed [QFP_VAL_W-1:0] sorted_value;
    logic                        end_of_run;
    logic                        overflow;
  } qfp_out_t;

  // Datapath commands, one per cycle.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_RANGE,
    OP_PIV_RD,
    OP_PIV_CAP,
    OP_L_RD,
    OP_L_INC,
    OP_TMP_CAP,
    OP_R_RD,
    OP_R_DEC,
    OP_SWAP1,
    OP_SWAP2,
    OP_FIN1,
    OP_FIN2,
    OP_PUSH_HI,
    OP_PUSH_LO,
    OP_EMIT_RD,
    OP_EMIT
  } qfp_op_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_POPW,
    ST_PRD,
    ST_PIV,
    ST_LRD,
    ST_LCHK,
    ST_RRD,
    ST_RCHK,
    ST_SWAP2,
    ST_FIN2,
    ST_PUSHA,
    ST_PUSHB,
    ST_ERD,
    ST_EOUT
  } qfp_state_e;

  // Datapath status back to the controller.
  typedef struct packed {
    logic sp_zero;    // range stack empty
    logic l_cont;     // left scan goes on
    logic r_cont;     // right scan goes on
    logic l_lt_r;     // pointers have not met
    logic emit_last;  // emitting the final stored word
  } qfp_status_t;

endpackage

/* sv/qfp_ctrl.sv */
// Sequencer of the quicksort block: load, partition loop, range stack, emit.
// Depends on qfp_pkg; drives qfp_dp through one command per cycle.
module qfp_ctrl import qfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        last_i,
  input  qfp_status_t status_i,
  output qfp_op_e     op_o,
  output logic        busy_o
);

  qfp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = OP_NOP;
    busy_o  = 1'b1;
    case (state_q)
      ST_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          op_o = OP_LOAD;
          if (last_i) state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        op_o    = OP_INIT;
        state_d = ST_POP;
      end
      ST_POP: begin
        if (status_i.sp_zero) begin
          state_d = ST_ERD;
        end else begin
          op_o    = OP_POP;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        op_o    = OP_RANGE;
        state_d = ST_PRD;
      end
      ST_PRD: begin
        op_o    = OP_PIV_RD;
        state_d = ST_PIV;
      end
      ST_PIV: begin
        op_o    = OP_PIV_CAP;
        state_d = ST_LRD;
      end
      ST_LRD: begin
        op_o    = OP_L_RD;
        state_d = ST_LCHK;
      end
      ST_LCHK: begin
        if (status_i.l_cont) begin
          op_o    = OP_L_INC;
          state_d = ST_LRD;
        end else begin
          op_o    = OP_TMP_CAP;
          state_d = ST_RRD;
        end
      end
      ST_RRD: begin
        op_o    = OP_R_RD;
        state_d = ST_RCHK;
      end
      ST_RCHK: begin
        if (status_i.r_cont) begin
          op_o    = OP_R_DEC;
          state_d = ST_RRD;
        end else if (status_i.l_lt_r) begin
          op_o    = OP_SWAP1;
          state_d = ST_SWAP2;
        end else begin
          op_o    = OP_FIN1;
          state_d = ST_FIN2;
        end
      end
      ST_SWAP2: begin
        op_o    = OP_SWAP2;
        state_d = ST_LRD;
      end
      ST_FIN2: begin
        op_o    = OP_FIN2;
        state_d = ST_PUSHA;
      end
      ST_PUSHA: begin
        op_o    = OP_PUSH_HI;
        state_d = ST_PUSHB;
      end
      ST_PUSHB: begin
        op_o    = OP_PUSH_LO;
        state_d = ST_POP;
      end
      ST_ERD: begin
        op_o    = OP_EMIT_RD;
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        op_o    = OP_EMIT;
        state_d = status_i.emit_last ? ST_LOAD : ST_ERD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

/* sv/qfp_dp.sv */
// Datapath of the quicksort block: element memory, range stack, pointers.
// Depends on qfp_pkg and quicksort_first_pivot_macros.svh; commanded by qfp_ctrl.
`include "quicksort_first_pivot_macros.svh"

module qfp_dp import qfp_pkg::*; #(
  parameter int DEPTH = QFP_DEPTH,
  parameter int WIDTH = QFP_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  qfp_op_e     op_i,
  input  qfp_in_t     in_word_i,
  output qfp_status_t status_o,
  output logic        out_valid_o,
  output qfp_out_t    out_word_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [2*AW-1:0]  stk_q [DEPTH];

  logic [WIDTH-1:0] rd_q, pivot_q, pivot_d, tmp_q, tmp_d;
  logic [2*AW-1:0]  stk_rd_q;
  logic [CW-1:0]    count_q, count_d, sp_q, sp_d, sp_m1, cnt_m1;
  logic             ovf_q, ovf_d;
  logic [AW-1:0]    k_q, k_d, lo_q, lo_d, hi_q, hi_d, l_q, l_d, r_q, r_d;

  logic             mem_we, mem_re, stk_we, stk_re;
  logic [AW-1:0]    mem_wa, mem_ra, stk_wa;
  logic [WIDTH-1:0] mem_wd;
  logic [2*AW-1:0]  stk_wd;
  logic             sp_room, push_hi_ok, push_lo_ok, rd_le_piv;

  assign sp_m1      = sp_q - CW'(1);
  assign cnt_m1     = count_q - CW'(1);
  assign sp_room    = sp_q < CW'(DEPTH);
  assign rd_le_piv  = $signed(rd_q) <= $signed(pivot_q);
  assign push_hi_ok = sp_room && ((CW'(r_q) + CW'(1)) < CW'(hi_q));
  assign push_lo_ok = sp_room && ((CW'(lo_q) + CW'(1)) < CW'(r_q));

  assign status_o.sp_zero   = (sp_q == '0);
  assign status_o.l_cont    = (l_q < hi_q) && rd_le_piv;
  assign status_o.r_cont    = (r_q > lo_q) && !rd_le_piv;
  assign status_o.l_lt_r    = (l_q < r_q);
  assign status_o.emit_last = ((CW'(k_q) + CW'(1)) == count_q);

  assign out_valid_o             = (op_i == OP_EMIT);
  assign out_word_o.sorted_value = QFP_VAL_W'(rd_q);
  assign out_word_o.end_of_run   = status_o.emit_last;
  assign out_word_o.overflow     = ovf_q;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    sp_d    = sp_q;
    k_d     = k_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    l_d     = l_q;
    r_d     = r_q;
    pivot_d = pivot_q;
    tmp_d   = tmp_q;
    mem_we  = 1'b0;
    mem_wa  = l_q;
    mem_wd  = rd_q;
    mem_re  = 1'b0;
    mem_ra  = l_q;
    stk_we  = 1'b0;
    stk_wa  = sp_q[AW-1:0];
    stk_wd  = {lo_q, hi_q};
    stk_re  = 1'b0;
    case (op_i)
      OP_LOAD: begin
        if (sp_room && (count_q < CW'(DEPTH))) begin
          mem_we  = 1'b1;
          mem_wa  = count_q[AW-1:0];
          mem_wd  = WIDTH'(in_word_i.value);
          count_d = count_q + CW'(1);
        end else if (count_q >= CW'(DEPTH)) begin
          ovf_d = 1'b1;
        end
      end
      OP_INIT: begin
        sp_d = '0;
        k_d  = '0;
        if (count_q >= CW'(2)) begin
          stk_we = 1'b1;
          stk_wa = '0;
          stk_wd = {AW'(0), cnt_m1[AW-1:0]};
          sp_d   = CW'(1);
        end
      end
      OP_POP: begin
        stk_re = 1'b1;
        sp_d   = sp_m1;
      end
      OP_RANGE: begin
        lo_d = stk_rd_q[2*AW-1:AW];
        hi_d = stk_rd_q[AW-1:0];
      end
      OP_PIV_RD: begin
        mem_re = 1'b1;
        mem_ra = lo_q;
      end
      OP_PIV_CAP: begin
        pivot_d = rd_q;
        l_d     = lo_q;
        r_d     = hi_q;
      end
      OP_L_RD: begin
        mem_re = 1'b1;
        mem_ra = l_q;
      end
      OP_L_INC: l_d = l_q + AW'(1);
      OP_TMP_CAP: tmp_d = rd_q;
      OP_R_RD: begin
        mem_re = 1'b1;
        mem_ra = r_q;
      end
      OP_R_DEC: r_d = r_q - AW'(1);
      OP_SWAP1: begin
        mem_we = 1'b1;
        mem_wa = l_q;
        mem_wd = rd_q;
      end
      OP_SWAP2: begin
        mem_we = 1'b1;
        mem_wa = r_q;
        mem_wd = tmp_q;
      end
      OP_FIN1: begin
        mem_we = 1'b1;
        mem_wa = lo_q;
        mem_wd = rd_q;
      end
      OP_FIN2: begin
        mem_we = 1'b1;
        mem_wa = r_q;
        mem_wd = pivot_q;
      end
      OP_PUSH_HI: begin
        if (push_hi_ok) begin
          stk_we = 1'b1;
          stk_wd = {r_q + AW'(1), hi_q};
          sp_d   = sp_q + CW'(1);
        end
      end
      OP_PUSH_LO: begin
        if (push_lo_ok) begin
          stk_we = 1'b1;
          stk_wd = {lo_q, r_q - AW'(1)};
          sp_d   = sp_q + CW'(1);
        end
      end
      OP_EMIT_RD: begin
        mem_re = 1'b1;
        mem_ra = k_q;
      end
      OP_EMIT: begin
        k_d = k_q + AW'(1);
        if (status_o.emit_last) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Element memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  // Range stack memory.
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_q[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_q <= stk_q[sp_m1[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      sp_q    <= '0;
      k_q     <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      sp_q    <= sp_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    l_q     <= l_d;
    r_q     <= r_d;
    pivot_q <= pivot_d;
    tmp_q   <= tmp_d;
  end

  `QFP_ASSERT_IMPL(a_l_in_range, op_i == OP_L_RD, l_q <= hi_q, "left pointer past range")
  `QFP_ASSERT_IMPL(a_r_in_range, op_i == OP_R_RD, r_q >= lo_q, "right pointer below range")

endmodule

/* sv/quicksort_first_pivot.sv */
// Top level of the quicksort block (first element of each range as pivot).
// Depends on qfp_pkg, qfp_ctrl, qfp_dp and quicksort_first_pivot_macros.svh.
//
// Load words one per cycle with start while busy is low; the word marked
// is_last is stored too and starts the sort. Up to DEPTH words are kept;
// further words (a marked one included) are dropped and every result of that
// run carries overflow. The sort runs in place in an element memory with one
// write port and one read port: each partition fetches the range and the
// pivot, lets each pointer read words in turn, swaps where needed, places the
// pivot and pushes each sub-range of more than one word while the range stack
// has room. Then the sorted words come out ascending, each on out_word_o for
// exactly one cycle with out_valid_o high; the last carries end_of_run. The
// receiver cannot stall: results must be taken as they come. busy goes high
// once the marked word is taken and stays high until the cycle after the last
// result. No clearing pass after reset.
`include "quicksort_first_pivot_macros.svh"

module quicksort_first_pivot import qfp_pkg::*; #(
  parameter int DEPTH = QFP_DEPTH,
  parameter int WIDTH = QFP_WIDTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  qfp_in_t  in_word_i,
  output logic     busy,
  output logic     out_valid_o,
  output qfp_out_t out_word_o
);

  qfp_op_e     op;
  qfp_status_t status;

  // Sequencer: owns the state and issues one datapath command per cycle.
  qfp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .last_i   (in_word_i.is_last),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy)
  );

  // Datapath: element memory, range stack, scan pointers and result word.
  qfp_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_word_i   (in_word_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // Results only appear while a run is in progress.
  `QFP_ASSERT_IMPL(a_out_while_busy, out_valid_o, busy, "result word while idle")
  // A marked word always starts a run.
  `QFP_ASSERT_NEXT(a_last_starts_run, start && !busy && in_word_i.is_last, busy, "no run after last word")
  // The final result releases the block.
  `QFP_ASSERT_NEXT(a_end_releases, out_valid_o && out_word_o.end_of_run, !busy, "busy after end of run")

endmodule
